// ===== hdl/conv2d_multichannel_assert.svh =====
// Assertion macros shared by the checker.
`ifndef CONV2D_MULTICHANNEL_ASSERT_SVH
`define CONV2D_MULTICHANNEL_ASSERT_SVH

// same-cycle implication, held off during reset
`define C2D_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("conv2d check failed");

// next-cycle implication, held off during reset
`define C2D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("conv2d check failed");

// next-cycle implication that also covers the reset cycles
`define C2D_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("conv2d check failed");

`endif

// ===== hdl/c2dmc_pkg.sv =====
package c2dmc_pkg;

  localparam int unsigned DEF_FEATURE_DEPTH = 4096;
  localparam int unsigned DEF_WEIGHT_DEPTH  = 256;
  localparam int unsigned DEF_BIAS_DEPTH    = 16;
  localparam int unsigned DEF_MAX_KERNEL    = 7;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned ADDR_W  = 12;
  localparam int unsigned CH_W    = 5;
  localparam int unsigned DIM_W   = 7;
  localparam int unsigned KS_W    = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned FI_W    = 20;
  localparam int unsigned WI_W    = 15;
  localparam int unsigned ACC_W   = 44;

  localparam logic [CH_W-1:0]  RST_IN_CHANNELS  = 5'd1;
  localparam logic [DIM_W-1:0] RST_IN_HEIGHT    = 7'd30;
  localparam logic [DIM_W-1:0] RST_IN_WIDTH     = 7'd30;
  localparam logic [CH_W-1:0]  RST_OUT_CHANNELS = 5'd16;
  localparam logic [DIM_W-1:0] RST_OUT_HEIGHT   = 7'd14;
  localparam logic [DIM_W-1:0] RST_OUT_WIDTH    = 7'd14;
  localparam logic [KS_W-1:0]  RST_KERNEL_SIZE  = 3'd3;
  localparam logic [KS_W-1:0]  RST_STRIDE       = 3'd2;

  typedef enum logic [1:0] {
    MODE_LOAD_FEATURE = 2'd0,
    MODE_LOAD_WEIGHT  = 2'd1,
    MODE_LOAD_BIAS    = 2'd2,
    MODE_COMPUTE      = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_CHANNELS  = 3'd0,
    CFG_IN_HEIGHT    = 3'd1,
    CFG_IN_WIDTH     = 3'd2,
    CFG_OUT_CHANNELS = 3'd3,
    CFG_OUT_HEIGHT   = 3'd4,
    CFG_OUT_WIDTH    = 3'd5,
    CFG_KERNEL_SIZE  = 3'd6,
    CFG_STRIDE       = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET0,
    ST_SET1,
    ST_SET2,
    ST_RUN,
    ST_DRAIN,
    ST_BIAS,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/conv2d_multichannel.sv =====
// Channel   Direction  Handshake           Payload
// in        request    in_valid/in_ready   mode, address, value, out_channel/row/col
// out       result     out_valid/out_ready sum, out_of_range, saturated
// cfg       write      cfg_we              cfg_index, cfg_data
//
// Loads give no result.
// A compute request does one multiply-accumulate per cycle, paced by the single
// read port of the feature and weight memories.
// Reset clears control and sets the configuration to its defaults; memories hold garbage until loaded.
// A finished result waits in the output register; a further request is taken
// meanwhile and stalls only at its own end while the previous result is unread.
module conv2d_multichannel #(
  parameter int unsigned FEATURE_DEPTH = c2dmc_pkg::DEF_FEATURE_DEPTH,
  parameter int unsigned WEIGHT_DEPTH  = c2dmc_pkg::DEF_WEIGHT_DEPTH,
  parameter int unsigned BIAS_DEPTH    = c2dmc_pkg::DEF_BIAS_DEPTH,
  parameter int unsigned MAX_KERNEL    = c2dmc_pkg::DEF_MAX_KERNEL
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_mode,
  input  logic [c2dmc_pkg::ADDR_W-1:0]         in_address,
  input  logic signed [c2dmc_pkg::DATA_W-1:0]  in_data,
  input  logic [3:0]                           in_out_channel,
  input  logic [5:0]                           in_out_row,
  input  logic [5:0]                           in_out_col,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [c2dmc_pkg::DATA_W-1:0]  out_sum,
  output logic                                 out_out_of_range,
  output logic                                 out_saturated,
  input  logic                                 cfg_we,
  input  logic [c2dmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [c2dmc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import c2dmc_pkg::*;

  localparam int unsigned FA_W = (FEATURE_DEPTH > 1) ? $clog2(FEATURE_DEPTH) : 1;
  localparam int unsigned WA_W = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
  localparam int unsigned BA_W = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;

  logic signed [DATA_W-1:0] feat_mem [FEATURE_DEPTH];
  logic signed [DATA_W-1:0] wgt_mem  [WEIGHT_DEPTH];
  logic signed [DATA_W-1:0] bias_mem [BIAS_DEPTH];

  logic [CH_W-1:0]  in_channels_r, out_channels_r;
  logic [DIM_W-1:0] in_height_r, in_width_r, out_height_r, out_width_r;
  logic [KS_W-1:0]  kernel_size_r, stride_r;

  state_t state_r, state_nxt;

  logic [3:0] oc_r;
  logic [5:0] orow_r, ocol_r;
  logic [8:0] r0_r, c0_r, ocic_r;
  logic [5:0] kk_r;
  logic [13:0] plane_r;
  logic [16:0] f_start_r;
  logic err_r;

  logic [FI_W-1:0] f_addr_r, f_row_r, f_plane_r;
  logic [WI_W-1:0] w_addr_r;
  logic [KS_W-1:0] kw_r, kh_r;
  logic [CH_W-1:0] ic_r;

  logic signed [DATA_W-1:0] f_q_r, w_q_r, b_q_r;
  logic rd_v_r, prod_v_r;
  logic signed [2*DATA_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;

  logic out_valid_r, out_oor_r, out_sat_r;
  logic signed [DATA_W-1:0] out_sum_r;

  logic accept, load_out;
  logic f_ok, w_ok;
  logic kw_last, kh_last, ic_last;
  logic signed [ACC_W-9:0] res;
  logic res_hi, res_lo;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign f_ok     = 32'(f_addr_r) < 32'(FEATURE_DEPTH);
  assign w_ok     = 32'(w_addr_r) < 32'(WEIGHT_DEPTH);
  assign kw_last  = KS_W'(kw_r + 1'b1) == kernel_size_r;
  assign kh_last  = KS_W'(kh_r + 1'b1) == kernel_size_r;
  assign ic_last  = CH_W'(ic_r + 1'b1) == in_channels_r;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign res      = acc_r[ACC_W-1:8];
  assign res_hi   = res > (ACC_W-8)'(32767);
  assign res_lo   = res < -(ACC_W-8)'(32768);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_channels_r  <= RST_IN_CHANNELS;
      in_height_r    <= RST_IN_HEIGHT;
      in_width_r     <= RST_IN_WIDTH;
      out_channels_r <= RST_OUT_CHANNELS;
      out_height_r   <= RST_OUT_HEIGHT;
      out_width_r    <= RST_OUT_WIDTH;
      kernel_size_r  <= RST_KERNEL_SIZE;
      stride_r       <= RST_STRIDE;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IN_CHANNELS:  in_channels_r  <= cfg_data[CH_W-1:0];
        CFG_IN_HEIGHT:    in_height_r    <= cfg_data;
        CFG_IN_WIDTH:     in_width_r     <= cfg_data;
        CFG_OUT_CHANNELS: out_channels_r <= cfg_data[CH_W-1:0];
        CFG_OUT_HEIGHT:   out_height_r   <= cfg_data;
        CFG_OUT_WIDTH:    out_width_r    <= cfg_data;
        CFG_KERNEL_SIZE:  kernel_size_r  <= cfg_data[KS_W-1:0];
        CFG_STRIDE:       stride_r       <= cfg_data[KS_W-1:0];
        default: ;
      endcase
    end
  end

  // memories: write on load, registered read
  always_ff @(posedge clk) begin
    if (accept && mode_t'(in_mode) == MODE_LOAD_FEATURE &&
        32'(in_address) < 32'(FEATURE_DEPTH)) begin
      feat_mem[FA_W'(in_address)] <= in_data;
    end
    if (state_r == ST_RUN && f_ok) begin
      f_q_r <= feat_mem[f_addr_r[FA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && mode_t'(in_mode) == MODE_LOAD_WEIGHT &&
        32'(in_address) < 32'(WEIGHT_DEPTH)) begin
      wgt_mem[WA_W'(in_address)] <= in_data;
    end
    if (state_r == ST_RUN && w_ok) begin
      w_q_r <= wgt_mem[w_addr_r[WA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && mode_t'(in_mode) == MODE_LOAD_BIAS &&
        32'(in_address) < 32'(BIAS_DEPTH)) begin
      bias_mem[BA_W'(in_address)] <= in_data;
    end
    if (state_r == ST_SET0 && 32'(oc_r) < 32'(BIAS_DEPTH)) begin
      b_q_r <= bias_mem[BA_W'(oc_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && mode_t'(in_mode) == MODE_COMPUTE) begin
          state_nxt = ST_SET0;
        end
      end
      ST_SET0: state_nxt = ST_SET1;
      ST_SET1: state_nxt = ST_SET2;
      ST_SET2: begin
        if (err_r || in_channels_r == '0 || kernel_size_r == '0) begin
          state_nxt = ST_BIAS;
        end else begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (kw_last && kh_last && ic_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !prod_v_r) begin
          state_nxt = ST_BIAS;
        end
      end
      ST_BIAS: state_nxt = ST_DONE;
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // address sequencing and setup
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        oc_r   <= in_out_channel;
        orow_r <= in_out_row;
        ocol_r <= in_out_col;
      end
      ST_SET0: begin
        r0_r    <= 9'(orow_r) * 9'(stride_r);
        c0_r    <= 9'(ocol_r) * 9'(stride_r);
        kk_r    <= 6'(kernel_size_r) * 6'(kernel_size_r);
        plane_r <= 14'(in_height_r) * 14'(in_width_r);
        err_r   <= (5'(oc_r) >= out_channels_r) || (7'(orow_r) >= out_height_r) ||
                   (7'(ocol_r) >= out_width_r) ||
                   (32'(kernel_size_r) > 32'(MAX_KERNEL)) ||
                   (32'(oc_r) >= 32'(BIAS_DEPTH));
      end
      ST_SET1: begin
        if ((10'(r0_r) + 10'(kernel_size_r) > 10'(in_height_r)) ||
            (10'(c0_r) + 10'(kernel_size_r) > 10'(in_width_r))) begin
          err_r <= 1'b1;
        end
        f_start_r <= 17'(r0_r) * 17'(in_width_r) + 17'(c0_r);
        ocic_r    <= 9'(oc_r) * 9'(in_channels_r);
      end
      ST_SET2: begin
        w_addr_r  <= WI_W'(ocic_r) * WI_W'(kk_r);
        f_addr_r  <= FI_W'(f_start_r);
        f_row_r   <= FI_W'(f_start_r);
        f_plane_r <= FI_W'(f_start_r);
        kw_r      <= '0;
        kh_r      <= '0;
        ic_r      <= '0;
      end
      ST_RUN: begin
        if (!f_ok || !w_ok) begin
          err_r <= 1'b1;
        end
        w_addr_r <= WI_W'(w_addr_r + 1'b1);
        if (!kw_last) begin
          kw_r     <= KS_W'(kw_r + 1'b1);
          f_addr_r <= FI_W'(f_addr_r + 1'b1);
        end else begin
          kw_r <= '0;
          if (!kh_last) begin
            kh_r     <= KS_W'(kh_r + 1'b1);
            f_row_r  <= FI_W'(f_row_r + FI_W'(in_width_r));
            f_addr_r <= FI_W'(f_row_r + FI_W'(in_width_r));
          end else begin
            kh_r      <= '0;
            ic_r      <= CH_W'(ic_r + 1'b1);
            f_plane_r <= FI_W'(f_plane_r + FI_W'(plane_r));
            f_row_r   <= FI_W'(f_plane_r + FI_W'(plane_r));
            f_addr_r  <= FI_W'(f_plane_r + FI_W'(plane_r));
          end
        end
      end
      default: ;
    endcase
  end

  // multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= (state_r == ST_RUN);
      prod_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= f_q_r * w_q_r;
    if (state_r == ST_SET2) begin
      acc_r <= '0;
    end else if (state_r == ST_BIAS) begin
      acc_r <= acc_r + ACC_W'(signed'({b_q_r, 8'd0}));
    end else if (prod_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_oor_r <= err_r;
      if (err_r) begin
        out_sum_r <= '0;
        out_sat_r <= 1'b0;
      end else if (res_hi) begin
        out_sum_r <= 16'sh7fff;
        out_sat_r <= 1'b1;
      end else if (res_lo) begin
        out_sum_r <= -16'sh8000;
        out_sat_r <= 1'b1;
      end else begin
        out_sum_r <= res[DATA_W-1:0];
        out_sat_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sum          = out_sum_r;
  assign out_out_of_range = out_oor_r;
  assign out_saturated    = out_sat_r;

endmodule

// ===== hdl/c2dmc_checker.sv =====
`include "conv2d_multichannel_assert.svh"

module c2dmc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [c2dmc_pkg::DATA_W-1:0] out_sum,
  input logic                                out_out_of_range,
  input logic                                out_saturated
);
  import c2dmc_pkg::*;

  `C2D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sum) && $stable(out_out_of_range) && $stable(out_saturated))
  `C2D_ASSERT_IMPLY(a_err_clean, out_valid && out_out_of_range, out_sum == '0 && !out_saturated)
  `C2D_ASSERT_IMPLY(a_sat_rail, out_valid && out_saturated, out_sum == 16'sh7fff || out_sum == -16'sh8000)
  `C2D_ASSERT_NEXT_ALWAYS(a_reset_quiet, !rst_n, !out_valid)

endmodule

bind conv2d_multichannel c2dmc_checker u_c2dmc_checker (.*);
